// File: hdl/keyframe_curve_evaluator_unit_assert.svh
// Assertion macros for the keyframe curve evaluator.
// The enclosing module must have clock and reset in scope.
`ifndef KEYFRAME_CURVE_EVALUATOR_UNIT_ASSERT_SVH
`define KEYFRAME_CURVE_EVALUATOR_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define KCE_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("kce assertion failed");
`define KCE_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("kce assertion failed");
`else
`define KCE_ASSERT_IMP(label, ante, cons)
`define KCE_ASSERT_NXT(label, ante, cons)
`endif
`endif

// File: hdl/kce_pkg.sv
package kce_pkg;

   localparam int DIV_STEPS = 16;
   localparam logic [16:0] U_ONE = 17'h10000;
   localparam logic signed [59:0] ROUND_HALF = 60'sd32768;

   typedef enum logic [1:0] {
      MODE_CONST   = 2'd0,
      MODE_LINEAR  = 2'd1,
      MODE_SMOOTH  = 2'd2,
      MODE_HERMITE = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_WRITTEN  = 3'd0,
      ST_FALLBACK = 3'd1,
      ST_FIRST    = 3'd2,
      ST_LAST     = 3'd3,
      ST_INTERP   = 3'd4
   } status_type;

   typedef enum logic [4:0] {
      OP_NONE   = 5'd0,
      OP_ACCEPT = 5'd1,
      OP_FIRST  = 5'd2,
      OP_LAST   = 5'd3,
      OP_SCAN   = 5'd4,
      OP_SPAN   = 5'd5,
      OP_UCHK   = 5'd6,
      OP_DIV    = 5'd7,
      OP_U2     = 5'd8,
      OP_U3     = 5'd9,
      OP_HERM   = 5'd10,
      OP_HM0    = 5'd11,
      OP_HM1    = 5'd12,
      OP_BLEND  = 5'd13,
      OP_PLO    = 5'd14,
      OP_PHI    = 5'd15,
      OP_SUM    = 5'd16,
      OP_FIN    = 5'd17
   } dp_op_type;

   typedef struct packed {
      logic [31:0] key_time;
      logic [31:0] key_value;
      mode_type    key_mode;
      logic [15:0] key_out_slope;
      logic [15:0] key_in_slope;
   } key_rec_type;

   typedef struct packed {
      dp_op_type op;
      logic      rd_en;
      logic      out_load;
   } cmd_type;

   typedef struct packed {
      logic t_le_rd;
      logic t_ge_rd;
      logic u_trivial;
      logic div_last;
   } flags_type;

endpackage

// File: hdl/kce_req_if.sv
interface kce_req_if;
   logic              valid;
   logic              ready;
   logic              req_type;
   logic [3:0]        key_index;
   logic signed [31:0] key_time;
   logic signed [31:0] key_value;
   logic [1:0]        key_mode;
   logic signed [15:0] key_out_slope;
   logic signed [15:0] key_in_slope;
   logic signed [31:0] eval_time;
   logic signed [31:0] fallback_value;

   modport source (
      output valid, req_type, key_index, key_time, key_value, key_mode,
             key_out_slope, key_in_slope, eval_time, fallback_value,
      input  ready
   );
   modport sink (
      input  valid, req_type, key_index, key_time, key_value, key_mode,
             key_out_slope, key_in_slope, eval_time, fallback_value,
      output ready
   );
endinterface

// File: hdl/kce_rsp_if.sv
interface kce_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [31:0] result_value;
   logic [2:0]        status;
   logic [3:0]        segment_index;

   modport source (
      output valid, result_value, status, segment_index,
      input  ready
   );
   modport sink (
      input  valid, result_value, status, segment_index,
      output ready
   );
endinterface

// File: hdl/kce_dp.sv
module kce_dp
   import kce_pkg::*;
#(
   parameter int MAX_KEYS = 16
) (
   input  logic                          clock,
   input  cmd_type                       cmd,
   input  logic [$clog2(MAX_KEYS)-1:0]   rd_addr,
   input  logic [$clog2(MAX_KEYS)-1:0]   seg_idx,
   input  logic                          req_type,
   input  logic [3:0]                    key_index,
   input  logic signed [31:0]            key_time,
   input  logic signed [31:0]            key_value,
   input  logic [1:0]                    key_mode,
   input  logic signed [15:0]            key_out_slope,
   input  logic signed [15:0]            key_in_slope,
   input  logic signed [31:0]            eval_time,
   input  logic signed [31:0]            fallback_value,
   output flags_type                     flags,
   output logic signed [31:0]            result_value,
   output logic [2:0]                    status,
   output logic [3:0]                    segment_index
);

   localparam int IDX_W = $clog2(MAX_KEYS);

   key_rec_type mem_ff [MAX_KEYS];
   key_rec_type rd_ff, left_ff, right_ff;

   logic signed [31:0] t_ff;
   logic signed [33:0] span_ff, rem_ff;
   logic signed [32:0] diff_ff;
   logic [16:0]        u_ff, u2_ff, u3_ff;
   logic [3:0]         cnt_ff;
   logic signed [19:0] h10_ff, h01_ff, h11_ff;
   logic signed [23:0] hm0_ff, hm1_ff;
   logic signed [25:0] bl_ff;
   logic signed [43:0] plo_ff;
   logic signed [41:0] phi_ff;
   logic signed [59:0] prod_ff;

   logic signed [31:0] pend_value_ff;
   status_type         pend_status_ff;
   logic [3:0]         pend_seg_ff;
   logic signed [31:0] out_value_ff;
   status_type         out_status_ff;
   logic [3:0]         out_seg_ff;

   logic [IDX_W+4:0]   kidx_wide;
   logic               widx_ok;
   key_rec_type        wr_rec;
   logic signed [33:0] div_sh;
   logic               div_ge;
   logic [33:0]        uu, u2u;
   logic signed [19:0] u_s, u2_s, u3_s;
   logic signed [35:0] hm0_p, hm1_p;
   logic signed [45:0] acc;
   logic signed [31:0] sat;
   logic [IDX_W+3:0]   seg_wide;

   assign kidx_wide = {(IDX_W+1)'(0), key_index};
   assign widx_ok   = kidx_wide < (IDX_W+5)'(MAX_KEYS);
   assign wr_rec    = '{key_time: key_time, key_value: key_value,
                        key_mode: mode_type'(key_mode),
                        key_out_slope: key_out_slope, key_in_slope: key_in_slope};

   assign flags.t_le_rd   = t_ff <= $signed(rd_ff.key_time);
   assign flags.t_ge_rd   = t_ff >= $signed(rd_ff.key_time);
   assign flags.u_trivial = (span_ff <= 0) || (rem_ff <= 0) || (rem_ff >= span_ff);
   assign flags.div_last  = cnt_ff == 4'(DIV_STEPS - 1);

   // restoring division, one quotient bit a cycle
   assign div_sh = rem_ff <<< 1;
   assign div_ge = div_sh >= span_ff;

   assign uu   = 34'(u_ff) * 34'(u_ff);
   assign u2u  = 34'(u2_ff) * 34'(u_ff);
   assign u_s  = {3'b000, u_ff};
   assign u2_s = {3'b000, u2_ff};
   assign u3_s = {3'b000, u3_ff};
   assign hm0_p = 36'(h10_ff) * 36'($signed(left_ff.key_out_slope));
   assign hm1_p = 36'(h11_ff) * 36'($signed(right_ff.key_in_slope));

   // prod_ff already carries the rounding half
   assign acc = 46'($signed(left_ff.key_value)) + 46'($signed(prod_ff[59:16]));
   always_comb begin
      if (acc[45:31] != {15{acc[45]}}) begin
         sat = acc[45] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         sat = acc[31:0];
      end
   end

   assign seg_wide = {4'b0000, seg_idx};

   always_ff @(posedge clock) begin
      if (cmd.op == OP_ACCEPT && !req_type && widx_ok) begin
         mem_ff[kidx_wide[IDX_W-1:0]] <= wr_rec;
      end
      if (cmd.rd_en) begin
         rd_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_ACCEPT: begin
            t_ff        <= eval_time;
            pend_seg_ff <= '0;
            if (!req_type) begin
               pend_value_ff  <= '0;
               pend_status_ff <= ST_WRITTEN;
            end else begin
               pend_value_ff  <= fallback_value;
               pend_status_ff <= ST_FALLBACK;
            end
         end
         OP_FIRST: begin
            left_ff <= rd_ff;
            if (flags.t_le_rd) begin
               pend_value_ff  <= rd_ff.key_value;
               pend_status_ff <= ST_FIRST;
            end
         end
         OP_LAST: begin
            if (flags.t_ge_rd) begin
               pend_value_ff  <= rd_ff.key_value;
               pend_status_ff <= ST_LAST;
            end
         end
         OP_SCAN: begin
            if (flags.t_ge_rd) begin
               left_ff <= rd_ff;
            end else begin
               right_ff <= rd_ff;
            end
         end
         OP_SPAN: begin
            span_ff <= 34'($signed(right_ff.key_time)) - 34'($signed(left_ff.key_time));
            rem_ff  <= 34'(t_ff) - 34'($signed(left_ff.key_time));
            diff_ff <= 33'($signed(right_ff.key_value)) - 33'($signed(left_ff.key_value));
         end
         OP_UCHK: begin
            cnt_ff <= '0;
            u_ff   <= (span_ff > 0 && rem_ff > 0 && rem_ff >= span_ff) ? U_ONE : '0;
         end
         OP_DIV: begin
            rem_ff <= div_ge ? div_sh - span_ff : div_sh;
            u_ff   <= {u_ff[15:0], div_ge};
            cnt_ff <= cnt_ff + 4'd1;
         end
         OP_U2: u2_ff <= uu[32:16];
         OP_U3: u3_ff <= u2u[32:16];
         OP_HERM: begin
            h10_ff <= u3_s - (u2_s <<< 1) + u_s;
            h01_ff <= (u2_s <<< 1) + u2_s - (u3_s <<< 1);
            h11_ff <= u3_s - u2_s;
         end
         OP_HM0: hm0_ff <= hm0_p[35:12];
         OP_HM1: hm1_ff <= hm1_p[35:12];
         OP_BLEND: begin
            unique case (left_ff.key_mode)
               MODE_CONST:   bl_ff <= '0;
               MODE_LINEAR:  bl_ff <= 26'($signed(u_s));
               MODE_SMOOTH:  bl_ff <= 26'(h01_ff);
               MODE_HERMITE: bl_ff <= 26'(h01_ff) + 26'(hm0_ff) + 26'(hm1_ff);
               default:      bl_ff <= '0;
            endcase
         end
         OP_PLO: plo_ff <= 44'($signed({1'b0, diff_ff[16:0]})) * 44'(bl_ff);
         OP_PHI: phi_ff <= 42'($signed(diff_ff[32:17])) * 42'(bl_ff);
         OP_SUM: prod_ff <= (60'(phi_ff) <<< 17) + 60'(plo_ff) + ROUND_HALF;
         OP_FIN: begin
            pend_value_ff  <= sat;
            pend_status_ff <= ST_INTERP;
            pend_seg_ff    <= seg_wide[3:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_value_ff  <= pend_value_ff;
         out_status_ff <= pend_status_ff;
         out_seg_ff    <= pend_seg_ff;
      end
   end

   assign result_value  = out_value_ff;
   assign status        = out_status_ff;
   assign segment_index = out_seg_ff;

endmodule

// File: hdl/kce_ctrl.sv
`include "keyframe_curve_evaluator_unit_assert.svh"

module kce_ctrl
   import kce_pkg::*;
#(
   parameter int MAX_KEYS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [4:0]                    csr_write_data,
   input  logic                          req_valid,
   input  logic                          req_type,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  flags_type                     flags,
   output cmd_type                       cmd,
   output logic [$clog2(MAX_KEYS)-1:0]   rd_addr,
   output logic [$clog2(MAX_KEYS)-1:0]   seg_idx
);

   localparam int IDX_W = $clog2(MAX_KEYS);
   localparam int CNT_W = $clog2(MAX_KEYS + 1);
   localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

   typedef enum logic [17:0] {
      S_IDLE  = 18'h00001,
      S_FIRST = 18'h00002,
      S_LAST  = 18'h00004,
      S_SCAN  = 18'h00008,
      S_SPAN  = 18'h00010,
      S_UCHK  = 18'h00020,
      S_DIV   = 18'h00040,
      S_U2    = 18'h00080,
      S_U3    = 18'h00100,
      S_HERM  = 18'h00200,
      S_HM0   = 18'h00400,
      S_HM1   = 18'h00800,
      S_BLEND = 18'h01000,
      S_PLO   = 18'h02000,
      S_PHI   = 18'h04000,
      S_SUM   = 18'h08000,
      S_FIN   = 18'h10000,
      S_DONE  = 18'h20000
   } state_type;

   state_type        state_ff, state_in;
   logic [4:0]       key_count_ff;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CMP_W-1:0] kc_wide;
   logic [CNT_W-1:0] n_m1;
   logic [IDX_W:0]   i_p1, i_p2;
   logic             out_free;

   assign kc_wide  = CMP_W'(key_count_ff);
   assign n_in     = (kc_wide > CMP_W'(MAX_KEYS)) ? CNT_W'(MAX_KEYS) : CNT_W'(kc_wide);
   assign n_m1     = n_ff - 1'b1;
   assign i_p1     = {1'b0, i_ff} + 1'b1;
   assign i_p2     = {1'b0, i_ff} + 2'd2;
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign seg_idx   = i_ff;

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      cmd.op       = OP_NONE;
      cmd.rd_en    = 1'b0;
      cmd.out_load = 1'b0;
      rd_addr      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op = OP_ACCEPT;
               i_in   = '0;
               if (!req_type || n_in == '0) begin
                  state_in = S_DONE;
               end else begin
                  cmd.rd_en = 1'b1;
                  state_in  = S_FIRST;
               end
            end
         end
         S_FIRST: begin
            cmd.op = OP_FIRST;
            if (flags.t_le_rd) begin
               state_in = S_DONE;
            end else begin
               cmd.rd_en = 1'b1;
               rd_addr   = n_m1[IDX_W-1:0];
               state_in  = S_LAST;
            end
         end
         S_LAST: begin
            cmd.op = OP_LAST;
            if (flags.t_ge_rd) begin
               state_in = S_DONE;
            end else begin
               cmd.rd_en = 1'b1;
               rd_addr   = i_p1[IDX_W-1:0];
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.op = OP_SCAN;
            // right key still at or before t: step along the table
            if (flags.t_ge_rd) begin
               i_in      = i_p1[IDX_W-1:0];
               cmd.rd_en = 1'b1;
               rd_addr   = i_p2[IDX_W-1:0];
            end else begin
               state_in = S_SPAN;
            end
         end
         S_SPAN: begin
            cmd.op   = OP_SPAN;
            state_in = S_UCHK;
         end
         S_UCHK: begin
            cmd.op   = OP_UCHK;
            state_in = flags.u_trivial ? S_U2 : S_DIV;
         end
         S_DIV: begin
            cmd.op = OP_DIV;
            if (flags.div_last) begin
               state_in = S_U2;
            end
         end
         S_U2: begin
            cmd.op   = OP_U2;
            state_in = S_U3;
         end
         S_U3: begin
            cmd.op   = OP_U3;
            state_in = S_HERM;
         end
         S_HERM: begin
            cmd.op   = OP_HERM;
            state_in = S_HM0;
         end
         S_HM0: begin
            cmd.op   = OP_HM0;
            state_in = S_HM1;
         end
         S_HM1: begin
            cmd.op   = OP_HM1;
            state_in = S_BLEND;
         end
         S_BLEND: begin
            cmd.op   = OP_BLEND;
            state_in = S_PLO;
         end
         S_PLO: begin
            cmd.op   = OP_PLO;
            state_in = S_PHI;
         end
         S_PHI: begin
            cmd.op   = OP_PHI;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.op   = OP_SUM;
            state_in = S_FIN;
         end
         S_FIN: begin
            cmd.op   = OP_FIN;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         key_count_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            key_count_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;
      if (state_ff == S_IDLE && req_valid) begin
         n_ff <= n_in;
      end
   end

   `KCE_ASSERT_NXT(a_eval_reads_first,
      state_ff == S_IDLE && req_valid && req_type && n_in != '0,
      state_ff == S_FIRST)
   `KCE_ASSERT_NXT(a_done_publishes, state_ff == S_DONE && out_free,
      rsp_valid_ff && state_ff == S_IDLE)
   `KCE_ASSERT_IMP(a_scan_in_table, state_ff == S_SCAN,
      (CNT_W + 1)'(i_ff) + 1'b1 < (CNT_W + 1)'(n_ff))

endmodule

// File: hdl/keyframe_curve_evaluator_unit.sv
// channel   dir  handshake          contents
// req_ch    in   valid/ready        key write or evaluate word
// rsp_ch    out  valid/ready        result_value, status, segment_index
// csr_*     in   write enable only  key_count
//
// An interpolated evaluate scans 1 to MAX_KEYS-1 keys, one key-table read each,
// then runs the restoring divider for u unless u is trivial.
// One word in flight; a finished result sits in the output register, so the
// next request is taken while rsp_ch is stalled. Synchronous reset, no clearing pass.
module keyframe_curve_evaluator_unit
   import kce_pkg::*;
#(
   parameter int MAX_KEYS = 16
) (
   input  logic       clock,
   input  logic       reset,
   kce_req_if.sink    req_ch,
   kce_rsp_if.source  rsp_ch,
   input  logic       csr_write_enable,
   input  logic [4:0] csr_write_data
);

   localparam int IDX_W = $clog2(MAX_KEYS);

   cmd_type          cmd;
   flags_type        flags;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] seg_idx;

   kce_ctrl #(.MAX_KEYS(MAX_KEYS)) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_ch.valid),
      .req_type         (req_ch.req_type),
      .req_ready        (req_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .flags            (flags),
      .cmd              (cmd),
      .rd_addr          (rd_addr),
      .seg_idx          (seg_idx)
   );

   kce_dp #(.MAX_KEYS(MAX_KEYS)) u_dp (
      .clock          (clock),
      .cmd            (cmd),
      .rd_addr        (rd_addr),
      .seg_idx        (seg_idx),
      .req_type       (req_ch.req_type),
      .key_index      (req_ch.key_index),
      .key_time       (req_ch.key_time),
      .key_value      (req_ch.key_value),
      .key_mode       (req_ch.key_mode),
      .key_out_slope  (req_ch.key_out_slope),
      .key_in_slope   (req_ch.key_in_slope),
      .eval_time      (req_ch.eval_time),
      .fallback_value (req_ch.fallback_value),
      .flags          (flags),
      .result_value   (rsp_ch.result_value),
      .status         (rsp_ch.status),
      .segment_index  (rsp_ch.segment_index)
   );

endmodule
